@@ hw/rtl/bsws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared widths and codes for the banked scanline window splitter.
// ----------------------------------------------------------------------------
package bsws_pkg;

  // field widths
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STRIDE_W = 16;
  localparam int unsigned WIN_W    = 18;
  localparam int unsigned ADV_W    = 8;
  localparam int unsigned BANK_W   = 16;
  localparam int unsigned WOFF_W   = 17;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // result kinds
  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_COPY   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_ADVANCE = 3'd4;

  // divider result handed back to the sequencer
  typedef struct packed {
    logic              done;
    logic [BANK_W-1:0] quot;
    logic [WIN_W-1:0]  rem;
  } div_res_t;

endpackage : bsws_pkg
`default_nettype wire

@@ hw/rtl/banked_scanline_window_splitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// banked_scanline_window_splitter
// Turns a scanline write request into bank select and copy commands.
// ----------------------------------------------------------------------------
// A request in range passes through these steps from its accepted beat to
// the next accepted beat: row times stride, a divider start, the bit-serial
// divider that splits the address into bank and window offset (32 quotient
// steps and a done strobe), the copy split, a bank select slot and a copy
// slot whether or not a select is needed, a second pair of such slots when
// its bytes spill into a second window, and the idle state that takes the
// next beat. Any stall on the result side adds to this.
// The input is not ready while a request is in work. A row at or beyond the
// line limit is taken and produces no commands. Configuration writes are
// always accepted and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module banked_scanline_window_splitter (
  input  wire                               clk,
  input  wire                               rst_n,
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [bsws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bsws_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request beats
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [bsws_pkg::ROW_W-1:0]        in_row,
  input  wire  [bsws_pkg::COUNT_W-1:0]      in_pixel_count,
  // command beats
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              out_kind,
  output logic [bsws_pkg::BANK_W-1:0]       out_bank_number,
  output logic [bsws_pkg::WOFF_W-1:0]       out_window_offset,
  output logic [bsws_pkg::COUNT_W-1:0]      out_copy_length,
  output logic [bsws_pkg::COUNT_W-1:0]      out_source_offset,
  output logic                              out_last
);
  import bsws_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DGO   = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_SEL1  = 3'd5;
  localparam logic [2:0] ST_COPY1 = 3'd6;
  localparam logic [2:0] ST_SEL2  = 3'd7;

  // configuration registers
  logic [ROW_W-1:0]    line_limit_r;
  logic [STRIDE_W-1:0] line_stride_r;
  logic [WIN_W-1:0]    window_step_r;
  logic [WIN_W-1:0]    window_bytes_r;
  logic [ADV_W-1:0]    bank_advance_r;

  logic [2:0]          state_r;
  logic                second_r;
  logic [ROW_W-1:0]    row_r;
  logic [COUNT_W-1:0]  count_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   offset_r;
  logic [BANK_W-1:0]   bank_r;
  logic [BANK_W-1:0]   selected_bank_r;
  logic [COUNT_W-1:0]  first_r;
  logic [COUNT_W-1:0]  rest_r;

  logic                div_start;
  div_res_t            div_res;
  logic                slot_free;
  logic                emit;
  logic [ADDR_W-1:0]   room;
  logic                room_short;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign div_start = (state_r == ST_DGO);
  assign slot_free = !out_valid || out_ready;

  // a command beat is loaded this cycle
  assign emit = slot_free && ((state_r == ST_COPY1) ||
                (((state_r == ST_SEL1) || (state_r == ST_SEL2)) &&
                 (selected_bank_r != bank_r)));

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r   <= '0;
      line_stride_r  <= STRIDE_W'(1);
      window_step_r  <= WIN_W'(65536);
      window_bytes_r <= WIN_W'(65536);
      bank_advance_r <= ADV_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_LIMIT:   line_limit_r   <= cfg_data[ROW_W-1:0];
        REG_LINE_STRIDE:  line_stride_r  <= cfg_data[STRIDE_W-1:0];
        REG_WINDOW_STEP:  window_step_r  <= cfg_data[WIN_W-1:0];
        REG_WINDOW_BYTES: window_bytes_r <= cfg_data[WIN_W-1:0];
        REG_BANK_ADVANCE: bank_advance_r <= cfg_data[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  // address split into bank and window offset
  bsws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (addr_r),
    .divisor  (window_step_r),
    .res      (div_res)
  );

  // window room, modulo 2^32
  assign room       = {{(ADDR_W-WIN_W){1'b0}}, window_bytes_r} - offset_r;
  assign room_short = (offset_r != '0) && (room < {{(ADDR_W-COUNT_W){1'b0}}, count_r});

  // request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      second_r        <= 1'b0;
      selected_bank_r <= '1;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_row < line_limit_r)) state_r <= ST_MUL;
        end
        ST_MUL:   state_r <= ST_DGO;
        ST_DGO:   state_r <= ST_DWAIT;
        ST_DWAIT: if (div_res.done) state_r <= ST_CALC;
        ST_CALC: begin
          second_r <= 1'b0;
          state_r  <= ST_SEL1;
        end
        ST_SEL1, ST_SEL2: begin
          if (selected_bank_r != bank_r) begin
            if (slot_free) begin
              selected_bank_r <= bank_r;
              state_r         <= ST_COPY1;
            end
          end else begin
            state_r <= ST_COPY1;
          end
        end
        ST_COPY1: begin
          if (slot_free) begin
            if (!second_r && (rest_r != '0)) begin
              second_r <= 1'b1;
              state_r  <= ST_SEL2;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // request datapath and command payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        row_r   <= in_row;
        count_r <= in_pixel_count;
      end
      ST_MUL: addr_r <= ADDR_W'(row_r) * ADDR_W'(line_stride_r);
      ST_DWAIT: begin
        if (div_res.done) begin
          // a zero step gives an all-ones bank and the whole address as the offset
          if (window_step_r == '0) begin
            bank_r   <= '1;
            offset_r <= addr_r;
          end else begin
            bank_r   <= div_res.quot;
            offset_r <= {{(ADDR_W-WIN_W){1'b0}}, div_res.rem};
          end
        end
      end
      ST_CALC: begin
        first_r <= room_short ? room[COUNT_W-1:0] : count_r;
        rest_r  <= count_r - (room_short ? room[COUNT_W-1:0] : count_r);
      end
      ST_SEL1, ST_SEL2: begin
        if ((selected_bank_r != bank_r) && slot_free) begin
          out_kind          <= KIND_SELECT;
          out_bank_number   <= bank_r;
          out_window_offset <= '0;
          out_copy_length   <= '0;
          out_source_offset <= '0;
          out_last          <= 1'b0;
        end
      end
      ST_COPY1: begin
        if (slot_free) begin
          out_kind        <= KIND_COPY;
          out_bank_number <= selected_bank_r;
          if (second_r) begin
            out_window_offset <= '0;
            out_copy_length   <= rest_r;
            out_source_offset <= first_r;
            out_last          <= 1'b1;
          end else begin
            out_window_offset <= offset_r[WOFF_W-1:0];
            out_copy_length   <= first_r;
            out_source_offset <= '0;
            out_last          <= (rest_r == '0);
            // next window for the remaining bytes
            bank_r            <= bank_r + {{(BANK_W-ADV_W){1'b0}}, bank_advance_r};
          end
        end
      end
      default: ;
    endcase
  end

endmodule : banked_scanline_window_splitter
`default_nettype wire

@@ hw/rtl/bsws_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsws_div
// Restoring divider, one quotient bit per cycle: 32-bit address by the
// 18-bit window step. Keeps the low quotient bits and the remainder.
// ----------------------------------------------------------------------------
module bsws_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire  [bsws_pkg::ADDR_W-1:0]         dividend,
  input  wire  [bsws_pkg::WIN_W-1:0]          divisor,
  output bsws_pkg::div_res_t                  res
);
  import bsws_pkg::*;

  localparam int unsigned CNT_W = $clog2(ADDR_W);

  logic [ADDR_W-1:0] dvd_r;
  logic [WIN_W-1:0]  dvs_r;
  logic [WIN_W-1:0]  rem_r;
  logic [BANK_W-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [WIN_W:0]    partial;
  logic [WIN_W:0]    diff;
  logic              ge;

  // one trial subtraction per cycle
  assign partial = {rem_r, dvd_r[ADDR_W-1]};
  assign ge      = partial >= {1'b0, dvs_r};
  assign diff    = partial - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ADDR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ADDR_W-2:0], 1'b0};
      quo_r <= {quo_r[BANK_W-2:0], ge};
      rem_r <= ge ? diff[WIN_W-1:0] : partial[WIN_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule : bsws_div
`default_nettype wire
